### sv/ptc_pkg.sv
// Shared types, constants and helpers for the pressure/temperature compensation block.
`timescale 1ns / 1ps

package ptc_pkg;

    // Raw pressure after the oversampling shift is at most 24 - 5 bits wide
    localparam int unsigned UP_W = 19;

    localparam logic [31:0] C_B6_OFFSET = 32'd4000;
    localparam logic [31:0] C_P_MUL1    = 32'd3038;
    localparam logic [31:0] C_P_MUL2    = 32'hFFFF_E343;  // -7357
    localparam logic [31:0] C_P_ADD     = 32'd3791;
    localparam logic [31:0] C_B7_SCALE  = 32'd50000;
    localparam logic [31:0] C_B4_BIAS   = 32'd32768;
    localparam logic [31:0] C_LARGE     = 32'h8000_0000;
    localparam logic [31:0] C_T_ROUND   = 32'd8;
    localparam logic [31:0] C_Q_ROUND   = 32'd2;

    typedef enum logic [1:0] {
        REG_CALIB_A = 2'd0,
        REG_CALIB_B = 2'd1,
        REG_CALIB_C = 2'd2,
        REG_OSS     = 2'd3
    } ptc_reg_idx_t;

    typedef struct packed {
        logic [15:0] ac1;
        logic [15:0] ac2;
        logic [15:0] ac3;
        logic [15:0] ac4;
        logic [15:0] ac5;
        logic [15:0] ac6;
        logic [15:0] b1;
        logic [15:0] b2;
        logic [15:0] mc;
        logic [15:0] md;
        logic [1:0]  oss;
    } ptc_coef_t;

    // Classified item handed from the front to the back
    typedef struct packed {
        logic [UP_W-1:0] up;
        logic [31:0]     x1;
        logic [31:0]     den_mag;
        logic            q_neg;
        logic            err;
    } ptc_item_t;

    typedef struct packed {
        logic [UP_W-1:0] up;
        logic [31:0]     x1;
        logic            q_neg;
        logic            err;
    } ptc_tdiv_tag_t;

    typedef struct packed {
        logic [15:0] t;
        logic        err;
        logic        big_q;
    } ptc_pdiv_tag_t;

    function automatic logic [31:0] sx16(input logic [15:0] v);
        return {{16{v[15]}}, v};
    endfunction

    function automatic logic [31:0] asr32(input logic [31:0] a, input logic [4:0] n);
        return $signed(a) >>> n;
    endfunction

endpackage

### sv/ptc_div.sv
// Pipelined unsigned restoring divider, one quotient bit per stage.
`timescale 1ns / 1ps

module ptc_div import ptc_pkg::*;
#(
    parameter int W     = 32,
    parameter int TAG_W = 1
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             en,
    input  logic             in_valid,
    input  logic [W-1:0]     num,
    input  logic [W-1:0]     den,
    input  logic [TAG_W-1:0] tag,
    output logic             out_valid,
    output logic [W-1:0]     quot,
    output logic [TAG_W-1:0] out_tag
);

    logic             v_reg   [W];
    logic [W-1:0]     rem_reg [W];
    logic [W-1:0]     num_reg [W];
    logic [W-1:0]     den_reg [W];
    logic [W-1:0]     q_reg   [W];
    logic [TAG_W-1:0] tag_reg [W];

    for (genvar i = 0; i < W; i++) begin : g_stage
        logic             v_prev;
        logic [W-1:0]     rem_prev;
        logic [W-1:0]     num_prev;
        logic [W-1:0]     den_prev;
        logic [W-1:0]     q_prev;
        logic [TAG_W-1:0] tag_prev;
        logic [W:0]       trial;
        logic             ge;
        logic [W:0]       diff;
        logic [W-1:0]     rem_next;

        if (i == 0) begin : g_first
            assign v_prev   = in_valid;
            assign rem_prev = '0;
            assign num_prev = num;
            assign den_prev = den;
            assign q_prev   = '0;
            assign tag_prev = tag;
        end else begin : g_rest
            assign v_prev   = v_reg[i-1];
            assign rem_prev = rem_reg[i-1];
            assign num_prev = num_reg[i-1];
            assign den_prev = den_reg[i-1];
            assign q_prev   = q_reg[i-1];
            assign tag_prev = tag_reg[i-1];
        end

        assign trial    = {rem_prev, num_prev[W-1]};
        assign ge       = trial >= {1'b0, den_prev};
        assign diff     = trial - {1'b0, den_prev};
        assign rem_next = ge ? diff[W-1:0] : trial[W-1:0];

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                v_reg[i] <= 1'b0;
            end
            else if (en)
            begin
                v_reg[i] <= v_prev;
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rem_reg[i] <= rem_next;
                num_reg[i] <= {num_prev[W-2:0], 1'b0};
                den_reg[i] <= den_prev;
                q_reg[i]   <= {q_prev[W-2:0], ge};
                tag_reg[i] <= tag_prev;
            end
        end
    end

    assign out_valid = v_reg[W-1];
    assign quot      = q_reg[W-1];
    assign out_tag   = tag_reg[W-1];

endmodule

### sv/ptc_front.sv
// Front end: accepts raw samples, forms X1 and the temperature divisor.
`timescale 1ns / 1ps

module ptc_front import ptc_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  ptc_coef_t coef,
    input  logic      in_valid,
    output logic      in_ready,
    input  logic [15:0] raw_temp,
    input  logic [23:0] raw_press,
    output logic      item_valid,
    input  logic      item_ready,
    output ptc_item_t item
);

    logic            en;
    logic            f1_v_reg;
    logic [31:0]     f1_prod_reg;
    logic [UP_W-1:0] f1_up_reg;
    logic            f2_v_reg;
    ptc_item_t       f2_item_reg;

    logic [31:0]     prod_next;
    logic [3:0]      shamt;
    logic [23:0]     up_full;
    logic [31:0]     x1_next;
    logic [31:0]     den_next;
    ptc_item_t       item_next;

    assign en       = !f2_v_reg || item_ready;
    assign in_ready = en;

    assign prod_next = ({16'd0, raw_temp} - {16'd0, coef.ac6}) * {16'd0, coef.ac5};
    assign shamt     = 4'd8 - {2'd0, coef.oss};
    assign up_full   = raw_press >> shamt;

    assign x1_next  = asr32(f1_prod_reg, 5'd15);
    assign den_next = x1_next + sx16(coef.md);

    always_comb
    begin
        item_next.up      = f1_up_reg;
        item_next.x1      = x1_next;
        item_next.den_mag = den_next[31] ? (32'd0 - den_next) : den_next;
        item_next.q_neg   = coef.mc[15] ^ den_next[31];
        item_next.err     = (den_next == 32'd0);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            f1_v_reg <= 1'b0;
            f2_v_reg <= 1'b0;
        end
        else if (en)
        begin
            f1_v_reg <= in_valid;
            f2_v_reg <= f1_v_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            f1_prod_reg <= prod_next;
            f1_up_reg   <= up_full[UP_W-1:0];
            f2_item_reg <= item_next;
        end
    end

    assign item_valid = f2_v_reg;
    assign item       = f2_item_reg;

endmodule

### sv/ptc_fifo.sv
// Small item queue between front and back.
`timescale 1ns / 1ps

module ptc_fifo import ptc_pkg::*;
#(
    parameter int DEPTH = 4
)
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      wr_valid,
    output logic      wr_ready,
    input  ptc_item_t wr_data,
    output logic      rd_valid,
    input  logic      rd_ready,
    output ptc_item_t rd_data
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    ptc_item_t      slot_reg [DEPTH];
    logic [AW-1:0]  wr_ptr_reg;
    logic [AW-1:0]  rd_ptr_reg;
    logic [CW-1:0]  count_reg;
    logic [AW-1:0]  wr_ptr_next;
    logic [AW-1:0]  rd_ptr_next;
    logic           push;
    logic           pop;

    assign wr_ready = (count_reg != CW'(DEPTH));
    assign rd_valid = (count_reg != '0);
    assign push     = wr_valid && wr_ready;
    assign pop      = rd_valid && rd_ready;
    assign rd_data  = slot_reg[rd_ptr_reg];

    assign wr_ptr_next = (wr_ptr_reg == AW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
    assign rd_ptr_next = (rd_ptr_reg == AW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_next;
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_next;
            end
            if (push && !pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (pop && !push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= wr_data;
        end
    end

endmodule

### sv/ptc_back.sv
// Back end: both divisions and the compensation arithmetic, with output register.
`timescale 1ns / 1ps

module ptc_back import ptc_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  ptc_coef_t   coef,
    input  logic        item_valid,
    output logic        item_ready,
    input  ptc_item_t   item,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [15:0] temp_tenths,
    output logic [31:0] press_pa,
    output logic        div_error
);

    localparam int TT_W = $bits(ptc_tdiv_tag_t);
    localparam int PT_W = $bits(ptc_pdiv_tag_t);

    logic en;

    // temperature division
    logic [31:0]     mc_num;
    logic [31:0]     tnum_mag;
    ptc_tdiv_tag_t   ttag_in;
    logic            td_v;
    logic [31:0]     td_q;
    logic [TT_W-1:0] td_tag_bits;
    ptc_tdiv_tag_t   td_tag;

    // stage 1
    logic [31:0] x2_next, b5_next, t32_next, b6_next;
    logic [15:0] t_next;
    logic        p1_v_reg;
    logic [15:0] p1_t_reg;
    logic [31:0] p1_b6_reg;
    logic [UP_W-1:0] p1_up_reg;
    logic        p1_err_reg;

    // stage 2
    logic        p2_v_reg;
    logic [31:0] p2_sqp_reg, p2_a2_reg, p2_a3_reg;
    logic [15:0] p2_t_reg;
    logic [UP_W-1:0] p2_up_reg;
    logic        p2_err_reg;

    // stage 3
    logic        p3_v_reg;
    logic [31:0] p3_sq_reg, p3_a2_reg, p3_a3_reg;
    logic [15:0] p3_t_reg;
    logic [UP_W-1:0] p3_up_reg;
    logic        p3_err_reg;

    // stage 4
    logic        p4_v_reg;
    logic [31:0] p4_b2s_reg, p4_b1s_reg, p4_a2_reg, p4_a3_reg;
    logic [15:0] p4_t_reg;
    logic [UP_W-1:0] p4_up_reg;
    logic        p4_err_reg;

    // stage 5
    logic [31:0] x3_next, b3_base, b3_shl, b3_next, y3_next, u_next;
    logic        p5_v_reg;
    logic [31:0] p5_b3_reg, p5_u_reg;
    logic [15:0] p5_t_reg;
    logic [UP_W-1:0] p5_up_reg;
    logic        p5_err_reg;

    // stage 6
    logic [31:0] b4_prod;
    logic        p6_v_reg;
    logic [31:0] p6_b4_reg, p6_d_reg;
    logic [15:0] p6_t_reg;
    logic        p6_err_reg;

    // stage 7
    logic        p7_v_reg;
    logic [31:0] p7_b7_reg, p7_b4_reg;
    logic [15:0] p7_t_reg;
    logic        p7_err_reg;

    // pressure division
    logic            big_q;
    logic [31:0]     pnum;
    ptc_pdiv_tag_t   ptag_in;
    logic            pd_v;
    logic [31:0]     pd_q;
    logic [PT_W-1:0] pd_tag_bits;
    ptc_pdiv_tag_t   pd_tag;

    // stages 8 to 10
    logic [31:0] p_next, pp_next;
    logic        p8_v_reg;
    logic [31:0] p8_p_reg, p8_m1_reg, p8_m2_reg;
    logic [15:0] p8_t_reg;
    logic        p8_err_reg;
    logic        p9_v_reg;
    logic [31:0] p9_p_reg, p9_m3_reg, p9_m2_reg;
    logic [15:0] p9_t_reg;
    logic        p9_err_reg;
    logic [31:0] corr_next, pf_next;
    logic        out_v_reg;
    logic [15:0] out_t_reg;
    logic [31:0] out_p_reg;
    logic        out_err_reg;

    assign en         = !out_v_reg || out_ready;
    assign item_ready = en;

    assign mc_num   = sx16(coef.mc) << 11;
    assign tnum_mag = mc_num[31] ? (32'd0 - mc_num) : mc_num;

    always_comb
    begin
        ttag_in.up    = item.up;
        ttag_in.x1    = item.x1;
        ttag_in.q_neg = item.q_neg;
        ttag_in.err   = item.err;
    end

    ptc_div #(.W(32), .TAG_W(TT_W)) u_tdiv (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (item_valid),
        .num       (tnum_mag),
        .den       (item.den_mag),
        .tag       (TT_W'(ttag_in)),
        .out_valid (td_v),
        .quot      (td_q),
        .out_tag   (td_tag_bits)
    );

    assign td_tag = ptc_tdiv_tag_t'(td_tag_bits);

    assign x2_next  = td_tag.q_neg ? (32'd0 - td_q) : td_q;
    assign b5_next  = td_tag.x1 + x2_next;
    assign t32_next = asr32(b5_next + C_T_ROUND, 5'd4);
    assign b6_next  = b5_next - C_B6_OFFSET;

    always_comb
    begin
        if (!t32_next[31] && (t32_next[30:15] != 16'd0))
        begin
            t_next = 16'h7FFF;
        end
        else if (t32_next[31] && (t32_next[30:15] != 16'hFFFF))
        begin
            t_next = 16'h8000;
        end
        else
        begin
            t_next = t32_next[15:0];
        end
    end

    assign x3_next = asr32(p4_b2s_reg, 5'd11) + asr32(p4_a2_reg, 5'd11);
    assign b3_base = (sx16(coef.ac1) << 2) + x3_next;
    assign b3_shl  = b3_base << coef.oss;
    assign b3_next = asr32(b3_shl + C_Q_ROUND, 5'd2);
    assign y3_next = asr32(asr32(p4_a3_reg, 5'd13) + asr32(p4_b1s_reg, 5'd16) + C_Q_ROUND,
                           5'd2);
    assign u_next  = y3_next + C_B4_BIAS;

    assign b4_prod = {16'd0, coef.ac4} * p5_u_reg;

    assign big_q = (p7_b7_reg >= C_LARGE);
    assign pnum  = big_q ? p7_b7_reg : {p7_b7_reg[30:0], 1'b0};

    always_comb
    begin
        ptag_in.t     = p7_t_reg;
        ptag_in.err   = p7_err_reg;
        ptag_in.big_q = big_q;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            p1_v_reg <= 1'b0;
            p2_v_reg <= 1'b0;
            p3_v_reg <= 1'b0;
            p4_v_reg <= 1'b0;
            p5_v_reg <= 1'b0;
            p6_v_reg <= 1'b0;
            p7_v_reg <= 1'b0;
        end
        else if (en)
        begin
            p1_v_reg <= td_v;
            p2_v_reg <= p1_v_reg;
            p3_v_reg <= p2_v_reg;
            p4_v_reg <= p3_v_reg;
            p5_v_reg <= p4_v_reg;
            p6_v_reg <= p5_v_reg;
            p7_v_reg <= p6_v_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            p1_t_reg   <= t_next;
            p1_b6_reg  <= b6_next;
            p1_up_reg  <= td_tag.up;
            p1_err_reg <= td_tag.err;

            p2_sqp_reg <= p1_b6_reg * p1_b6_reg;
            p2_a2_reg  <= sx16(coef.ac2) * p1_b6_reg;
            p2_a3_reg  <= sx16(coef.ac3) * p1_b6_reg;
            p2_t_reg   <= p1_t_reg;
            p2_up_reg  <= p1_up_reg;
            p2_err_reg <= p1_err_reg;

            p3_sq_reg  <= asr32(p2_sqp_reg, 5'd12);
            p3_a2_reg  <= p2_a2_reg;
            p3_a3_reg  <= p2_a3_reg;
            p3_t_reg   <= p2_t_reg;
            p3_up_reg  <= p2_up_reg;
            p3_err_reg <= p2_err_reg;

            p4_b2s_reg <= sx16(coef.b2) * p3_sq_reg;
            p4_b1s_reg <= sx16(coef.b1) * p3_sq_reg;
            p4_a2_reg  <= p3_a2_reg;
            p4_a3_reg  <= p3_a3_reg;
            p4_t_reg   <= p3_t_reg;
            p4_up_reg  <= p3_up_reg;
            p4_err_reg <= p3_err_reg;

            p5_b3_reg  <= b3_next;
            p5_u_reg   <= u_next;
            p5_t_reg   <= p4_t_reg;
            p5_up_reg  <= p4_up_reg;
            p5_err_reg <= p4_err_reg;

            p6_b4_reg  <= {15'd0, b4_prod[31:15]};
            p6_d_reg   <= {{(32-UP_W){1'b0}}, p5_up_reg} - p5_b3_reg;
            p6_t_reg   <= p5_t_reg;
            p6_err_reg <= p5_err_reg;

            p7_b7_reg  <= p6_d_reg * (C_B7_SCALE >> coef.oss);
            p7_b4_reg  <= p6_b4_reg;
            p7_t_reg   <= p6_t_reg;
            p7_err_reg <= p6_err_reg || (p6_b4_reg == 32'd0);
        end
    end

    ptc_div #(.W(32), .TAG_W(PT_W)) u_pdiv (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (p7_v_reg),
        .num       (pnum),
        .den       (p7_b4_reg),
        .tag       (PT_W'(ptag_in)),
        .out_valid (pd_v),
        .quot      (pd_q),
        .out_tag   (pd_tag_bits)
    );

    assign pd_tag  = ptc_pdiv_tag_t'(pd_tag_bits);
    assign p_next  = pd_tag.big_q ? {pd_q[30:0], 1'b0} : pd_q;
    assign pp_next = asr32(p_next, 5'd8);

    assign corr_next = asr32(asr32(p9_m3_reg, 5'd16) + asr32(p9_m2_reg, 5'd16) + C_P_ADD,
                             5'd4);
    assign pf_next   = p9_p_reg + corr_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            p8_v_reg  <= 1'b0;
            p9_v_reg  <= 1'b0;
            out_v_reg <= 1'b0;
        end
        else if (en)
        begin
            p8_v_reg  <= pd_v;
            p9_v_reg  <= p8_v_reg;
            out_v_reg <= p9_v_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            p8_p_reg    <= p_next;
            p8_m1_reg   <= pp_next * pp_next;
            p8_m2_reg   <= C_P_MUL2 * p_next;
            p8_t_reg    <= pd_tag.t;
            p8_err_reg  <= pd_tag.err;

            p9_p_reg    <= p8_p_reg;
            p9_m3_reg   <= p8_m1_reg * C_P_MUL1;
            p9_m2_reg   <= p8_m2_reg;
            p9_t_reg    <= p8_t_reg;
            p9_err_reg  <= p8_err_reg;

            out_t_reg   <= p9_err_reg ? 16'd0 : p9_t_reg;
            out_p_reg   <= p9_err_reg ? 32'd0 : pf_next;
            out_err_reg <= p9_err_reg;
        end
    end

    assign out_valid   = out_v_reg;
    assign temp_tenths = out_t_reg;
    assign press_pa    = out_p_reg;
    assign div_error   = out_err_reg;

endmodule

### sv/pressure_temp_compensation.sv
// Top level of the pressure/temperature compensation block.
`timescale 1ns / 1ps

// Compensates one raw temperature word and one raw 24-bit pressure reading per
// item using the stock 32-bit integer calibration scheme, giving temperature in
// tenths of a degree (saturated to 16 bits) and pressure in pascals. Calibration
// words and the oversampling setting are written through the cfg port (index 0..3);
// the user must do so only while the block is idle, which the block itself does
// not enforce; writes are always taken. The block accepts one item per clock
// while the queue has room and returns one result per item, in order. The item
// passes 77 registers, the first loaded at the accepting edge - two front stages,
// one slot register in the item queue, a 32-stage temperature divider, seven
// arithmetic stages, a 32-stage pressure divider and three final stages ending in
// the output register. The two one-bit-per-stage dividers set the latency. A zero
// divisor in either division gives div_error = 1 with both values zero. The front
// and back stall separately; the queue (FIFO_DEPTH items) absorbs the difference.
module pressure_temp_compensation import ptc_pkg::*;
#(
    parameter int FIFO_DEPTH = 4
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [63:0] cfg_data,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [15:0] raw_temp,
    input  logic [23:0] raw_press,
    output logic        out_valid,
    input  logic        out_ready,
    output logic signed [15:0] temp_tenths,
    output logic signed [31:0] press_pa,
    output logic        div_error
);

    logic [63:0] calib_a_reg;
    logic [63:0] calib_b_reg;
    logic [63:0] calib_c_reg;
    logic [1:0]  oss_reg;
    ptc_coef_t   coef;

    logic        front_valid;
    logic        fifo_wr_ready;
    ptc_item_t   front_item;
    logic        back_valid;
    logic        back_ready;
    ptc_item_t   back_item;
    logic [15:0] temp_bits;
    logic [31:0] press_bits;

    assign cfg_ready = 1'b1;

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            calib_a_reg <= '0;
            calib_b_reg <= '0;
            calib_c_reg <= '0;
            oss_reg     <= '0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (ptc_reg_idx_t'(cfg_index))
                REG_CALIB_A: calib_a_reg <= cfg_data;
                REG_CALIB_B: calib_b_reg <= cfg_data;
                REG_CALIB_C: calib_c_reg <= cfg_data;
                REG_OSS:     oss_reg     <= cfg_data[1:0];
                default:     oss_reg     <= oss_reg;
            endcase
        end
    end

    // Coefficient unpacking; MB and the low word of calib C are unused
    always_comb
    begin
        coef.ac1 = calib_a_reg[63:48];
        coef.ac2 = calib_a_reg[47:32];
        coef.ac3 = calib_a_reg[31:16];
        coef.ac4 = calib_a_reg[15:0];
        coef.ac5 = calib_b_reg[63:48];
        coef.ac6 = calib_b_reg[47:32];
        coef.b1  = calib_b_reg[31:16];
        coef.b2  = calib_b_reg[15:0];
        coef.mc  = calib_c_reg[47:32];
        coef.md  = calib_c_reg[31:16];
        coef.oss = oss_reg;
    end

    ptc_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .coef       (coef),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .raw_temp   (raw_temp),
        .raw_press  (raw_press),
        .item_valid (front_valid),
        .item_ready (fifo_wr_ready),
        .item       (front_item)
    );

    ptc_fifo #(.DEPTH(FIFO_DEPTH)) u_fifo (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_valid (front_valid),
        .wr_ready (fifo_wr_ready),
        .wr_data  (front_item),
        .rd_valid (back_valid),
        .rd_ready (back_ready),
        .rd_data  (back_item)
    );

    ptc_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .coef        (coef),
        .item_valid  (back_valid),
        .item_ready  (back_ready),
        .item        (back_item),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .temp_tenths (temp_bits),
        .press_pa    (press_bits),
        .div_error   (div_error)
    );

    assign temp_tenths = $signed(temp_bits);
    assign press_pa    = $signed(press_bits);

`ifndef ASSERT_OFF
    a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && div_error |-> (temp_tenths == 16'sd0) && (press_pa == 32'sd0))
        else $error("error result carries nonzero values");

    a_front_hold: assert property (@(posedge clk) disable iff (!rst_n)
        front_valid && !fifo_wr_ready |=> front_valid && $stable(front_item))
        else $error("front item lost while queue full");

    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        !in_ready |-> front_valid && !fifo_wr_ready)
        else $error("front stalled without a blocked item");
`endif

endmodule

### tb/pressure_temp_compensation_test.sv
// Testbench for the pressure/temperature compensation block.
`timescale 1ns / 1ps

module pressure_temp_compensation_test import ptc_pkg::*;;

    // Clock, reset and the block's ports
    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [1:0]  cfg_index = '0;
    logic [63:0] cfg_data = '0;
    logic        in_valid = 1'b0;
    logic        in_ready;
    logic [15:0] raw_temp = '0;
    logic [23:0] raw_press = '0;
    logic        out_valid;
    logic        out_ready = 1'b0;
    logic signed [15:0] temp_tenths;
    logic signed [31:0] press_pa;
    logic        div_error;

    // One expected compensation result
    typedef struct {
        logic signed [15:0] temp;
        logic signed [31:0] press;
        logic               err;
    } comp_result_t;

    comp_result_t expected_results[$];

    // Local copy of the calibration registers
    logic [63:0] cal_a = '0;
    logic [63:0] cal_b = '0;
    logic [63:0] cal_c = '0;
    logic [1:0]  oss_setting = '0;

    int  fail_count = 0;
    int  idle_cycles = 0;
    bit  sink_idle_off = 1'b0;  // no stalls on the result side
    bit  src_idle_off = 1'b0;   // no gaps on the item side
    bit  hold_sink = 1'b0;      // long receiver hold-off
    int  hold_count = 0;

    localparam int WATCHDOG_LIMIT = 20000;
    localparam int DRAIN_CYCLES   = 120;

    pressure_temp_compensation dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .raw_temp   (raw_temp),
        .raw_press  (raw_press),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .temp_tenths(temp_tenths),
        .press_pa   (press_pa),
        .div_error  (div_error)
    );

    always #10 clk = ~clk;

    function automatic logic signed [31:0] s16(input logic [15:0] v);
        return $signed({{16{v[15]}}, v});
    endfunction

    // Datasheet-style integer compensation; all 32-bit math wraps
    function automatic comp_result_t compensate(input logic [15:0] ut_raw,
                                                input logic [23:0] press_raw);
        comp_result_t r;
        logic signed [31:0] ac1, ac2, ac3, ac5, ac6, b1, b2, mc, md;
        logic [31:0] ac4, up, b4, b7, q;
        logic signed [31:0] x1, x2, x3, b3, b5, b6, sq, p, t, den;
        logic signed [63:0] num;
        ac1 = s16(cal_a[63:48]);
        ac2 = s16(cal_a[47:32]);
        ac3 = s16(cal_a[31:16]);
        ac4 = {16'd0, cal_a[15:0]};
        ac5 = {16'd0, cal_b[63:48]};
        ac6 = {16'd0, cal_b[47:32]};
        b1  = s16(cal_b[31:16]);
        b2  = s16(cal_b[15:0]);
        mc  = s16(cal_c[47:32]);
        md  = s16(cal_c[31:16]);
        up  = {8'd0, press_raw} >> (8 - oss_setting);
        r.temp = '0;
        r.press = '0;
        r.err = 1'b1;

        x1 = (($signed({16'd0, ut_raw}) - ac6) * ac5) >>> 15;
        den = x1 + md;
        if (den == 0)
            return r;
        num = 64'(mc) * 64'sd2048;
        x2 = 32'(num / 64'(den));
        b5 = x1 + x2;
        t = (b5 + 8) >>> 4;
        if (t > 32767) t = 32767;
        if (t < -32768) t = -32768;

        b6 = b5 - 4000;
        sq = (b6 * b6) >>> 12;
        x1 = (b2 * sq) >>> 11;
        x2 = (ac2 * b6) >>> 11;
        x3 = x1 + x2;
        b3 = (((ac1 * 4 + x3) << oss_setting) + 2) >>> 2;
        x1 = (ac3 * b6) >>> 13;
        x2 = (b1 * sq) >>> 16;
        x3 = (x1 + x2 + 2) >>> 2;
        b4 = (ac4 * (32'(x3) + 32'd32768)) >> 15;
        if (b4 == 0)
            return r;
        b7 = (up - 32'(b3)) * (32'd50000 >> oss_setting);
        if (b7 < 32'h8000_0000)
            q = (b7 * 2) / b4;
        else
            q = (b7 / b4) * 2;
        p = $signed(q);
        x1 = (p >>> 8) * (p >>> 8);
        x1 = (x1 * 3038) >>> 16;
        x2 = (-32'sd7357 * p) >>> 16;
        p = p + ((x1 + x2 + 3791) >>> 4);
        r.temp = t[15:0];
        r.press = p;
        r.err = 1'b0;
        return r;
    endfunction

    // Random idle burst, about one time in four
    task automatic maybe_gap();
        if (!src_idle_off && $urandom_range(3) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(11, 1)) @(posedge clk);
        end
    endtask

    // Send one item and queue its expected result; valid stays high into the next item
    task automatic send_item(input logic [15:0] ut_raw, input logic [23:0] press_raw);
        maybe_gap();
        in_valid  <= 1'b1;
        raw_temp  <= ut_raw;
        raw_press <= press_raw;
        expected_results.push_back(compensate(ut_raw, press_raw));
        do @(posedge clk); while (!in_ready);
    endtask

    task automatic wait_drained();
        in_valid <= 1'b0;
        while (expected_results.size() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input ptc_reg_idx_t idx, input logic [63:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        @(posedge clk);
        case (idx)
            REG_CALIB_A: cal_a = val;
            REG_CALIB_B: cal_b = val;
            REG_CALIB_C: cal_c = val;
            REG_OSS:     oss_setting = val[1:0];
            default: ;
        endcase
    endtask

    // Coefficients close to a real sensor's, with random spread
    task automatic load_typical(input logic [1:0] oss);
        logic [15:0] ac1, ac2, ac3, ac4, ac5, ac6, b1, b2, mb, mc, md;
        ac1 = 16'(408 + $urandom_range(16000));
        ac2 = 16'(-72 - $urandom_range(1000));
        ac3 = 16'(-14383 + $urandom_range(2000));
        ac4 = 16'(20000 + $urandom_range(20000));
        ac5 = 16'(20000 + $urandom_range(20000));
        ac6 = 16'(15000 + $urandom_range(20000));
        b1  = 16'(6190 - $urandom_range(500));
        b2  = 16'(4 + $urandom_range(100));
        mb  = 16'h8000;
        mc  = 16'(-8711 + $urandom_range(4000));
        md  = 16'(2868 + $urandom_range(2000));
        write_reg(REG_CALIB_A, {ac1, ac2, ac3, ac4});
        write_reg(REG_CALIB_B, {ac5, ac6, b1, b2});
        write_reg(REG_CALIB_C, {mb, mc, md, 16'($urandom)});
        write_reg(REG_OSS, {62'd0, oss});
    endtask

    // Result side: random stalls, long hold-off, and field checks
    always @(posedge clk) begin
        if (hold_sink)
            out_ready <= 1'b0;
        else if (sink_idle_off)
            out_ready <= 1'b1;
        else if (idle_cycles > 0)
            out_ready <= 1'b0;
        else
            out_ready <= ($urandom_range(5) != 0);
    end

    always @(posedge clk) begin
        if (idle_cycles > 0)
            idle_cycles <= idle_cycles - 1;
        else if (!sink_idle_off && $urandom_range(7) == 0)
            idle_cycles <= $urandom_range(11, 1);
    end

    always @(posedge clk) begin
        comp_result_t e;
        if (rst_n && out_valid && out_ready) begin
            if (expected_results.size() == 0) begin
                $error("result with nothing expected");
                fail_count++;
            end else begin
                e = expected_results.pop_front();
                if (div_error !== e.err) begin
                    $error("div_error exp %0d got %0d", e.err, div_error);
                    fail_count++;
                end
                if (temp_tenths !== e.temp) begin
                    $error("temp_tenths exp %0d got %0d", e.temp, temp_tenths);
                    fail_count++;
                end
                if (press_pa !== e.press) begin
                    $error("press_pa exp %0d got %0d", e.press, press_pa);
                    fail_count++;
                end
            end
        end
    end

    // Long receiver hold-off, counted here
    always @(posedge clk) begin
        if (hold_count > 0) begin
            hold_count <= hold_count - 1;
            if (hold_count == 1)
                hold_sink <= 1'b0;
        end
    end

    // Watchdog on cycles with no accepted item, result or configuration write
    int stuck = 0;
    always @(posedge clk) begin
        if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
            stuck <= 0;
        else
            stuck <= stuck + 1;
        if (stuck >= WATCHDOG_LIMIT) begin
            $display("[pressure_temp_compensation] ERROR");
            $finish;
        end
    end

    // Reset registers, extreme fields, all-zero / all-one inputs
    task automatic test_reset_defaults();
        send_item(16'h0000, 24'h000000);
        send_item(16'hFFFF, 24'hFFFFFF);
        wait_drained();
    endtask

    // Both zero-divisor cases plus the extremes of raw inputs
    task automatic test_special_cases();
        // temperature divisor zero: ac5 = 0 gives x1 = 0, md = 0
        write_reg(REG_CALIB_A, 64'h1234_FF00_C000_8000);
        write_reg(REG_CALIB_B, 64'h0000_1000_1800_0004);
        write_reg(REG_CALIB_C, 64'h8000_DDDD_0000_0000);
        send_item(16'd27898, 24'h5D2300);
        wait_drained();
        // pressure divisor zero: ac4 = 0
        write_reg(REG_CALIB_C, 64'h8000_DDDD_0B34_0000);
        write_reg(REG_CALIB_A, 64'h1234_FF00_C000_0000);
        send_item(16'd27898, 24'h5D2300);
        wait_drained();
        // datasheet example, oss 0
        write_reg(REG_CALIB_A, {16'd408, -16'sd72, -16'sd14383, 16'd32741});
        write_reg(REG_CALIB_B, {16'd32757, 16'd23153, 16'd6190, 16'd4});
        write_reg(REG_CALIB_C, {16'h8000, -16'sd8711, 16'd2868, 16'h0000});
        write_reg(REG_OSS, 64'd0);
        send_item(16'd27898, 24'd23843 << 8);
        send_item(16'h0000, 24'hFFFFFF);
        send_item(16'hFFFF, 24'h000000);
        send_item(16'h8000, 24'h800000);
        send_item(16'h7FFF, 24'h7FFFFF);
        wait_drained();
        // all coefficients at extremes
        write_reg(REG_CALIB_A, 64'hFFFF_FFFF_FFFF_FFFF);
        write_reg(REG_CALIB_B, 64'hFFFF_FFFF_FFFF_FFFF);
        write_reg(REG_CALIB_C, 64'hFFFF_FFFF_FFFF_FFFF);
        write_reg(REG_OSS, 64'd3);
        send_item(16'h0000, 24'h000000);
        send_item(16'hFFFF, 24'hFFFFFF);
        wait_drained();
        write_reg(REG_CALIB_A, 64'h7FFF_8000_7FFF_FFFF);
        write_reg(REG_CALIB_B, 64'h0001_FFFF_8000_7FFF);
        write_reg(REG_CALIB_C, 64'h0000_7FFF_8000_FFFF);
        send_item(16'h5555, 24'hAAAAAA);
        send_item(16'hAAAA, 24'h555555);
        wait_drained();
    endtask

    // Random items over each oversampling setting with realistic coefficients
    task automatic test_random_typical();
        for (int ph = 0; ph < 4; ph++) begin
            load_typical(2'(ph));
            repeat (110)
                send_item(16'(20000 + $urandom_range(20000)), 24'($urandom));
            wait_drained();
        end
    endtask

    // Fully random coefficients and inputs: wrapping, large quotients, errors
    task automatic test_random_wild();
        for (int ph = 0; ph < 3; ph++) begin
            write_reg(REG_CALIB_A, {$urandom, $urandom});
            write_reg(REG_CALIB_B, {$urandom, $urandom});
            write_reg(REG_CALIB_C, {$urandom, $urandom});
            write_reg(REG_OSS, 64'($urandom_range(3)));
            repeat (50) send_item(16'($urandom), 24'($urandom));
            wait_drained();
        end
    endtask

    // Receiver holds off while items keep coming, then sender waits for drain
    task automatic test_backpressure();
        load_typical(2'd1);
        hold_sink = 1'b1;
        hold_count = 400;
        repeat (150) send_item(16'($urandom), 24'($urandom));
        wait_drained();
        repeat (20) send_item(16'($urandom), 24'($urandom));
        wait_drained();
    endtask

    // No idling at all: back-to-back items and results
    task automatic test_full_rate();
        src_idle_off = 1'b1;
        sink_idle_off = 1'b1;
        load_typical(2'd2);
        repeat (100) send_item(16'($urandom), 24'($urandom));
        wait_drained();
    endtask

    initial begin
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_reset_defaults();
        test_special_cases();
        test_random_typical();
        test_random_wild();
        test_backpressure();
        test_full_rate();
        if (fail_count == 0 && expected_results.size() == 0)
            $display("[pressure_temp_compensation] OK");
        else
            $display("[pressure_temp_compensation] ERROR");
        $finish;
    end

endmodule
